// File: design/dda_pkg.sv
// Shared constants, types and codes of the DDA line pixel generator.
`default_nettype none
package dda_pkg;
	// Coordinate and fixed-point sizes.
	localparam int COORD_BITS = 10;
	localparam int FRAC_BITS  = 16;

	// Position: unsigned integer part plus fraction.
	localparam int POS_W  = COORD_BITS + FRAC_BITS;
	// Increment: signed, magnitude at most 1.0.
	localparam int STEP_W = FRAC_BITS + 2;
	// Quotient of the increment divider: one integer bit plus fraction.
	localparam int QUO_W  = FRAC_BITS + 1;

	// Action codes of an input item.
	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_STEP = 1'b1;

	typedef logic [COORD_BITS-1:0] coord_t;

	// Sequencer states of the top level.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV_X,
		ST_DIV_Y
	} dda_state_t;

	// Request to the shared divider.
	typedef struct packed {
		logic   start;
		coord_t num;
		coord_t den;
	} div_req_t;

	// Response of the shared divider.
	typedef struct packed {
		logic             done;
		logic [QUO_W-1:0] quo;
	} div_rsp_t;
endpackage
`default_nettype wire

// File: design/dda_if.sv
// Valid/ready channel interfaces for line input items and pixel result items.
`default_nettype none
interface dda_in_if import dda_pkg::*; ();
	logic   valid;
	logic   ready;
	logic   action;
	coord_t start_x;
	coord_t start_y;
	coord_t end_x;
	coord_t end_y;

	modport source (output valid, action, start_x, start_y, end_x, end_y, input ready);
	modport sink (input valid, action, start_x, start_y, end_x, end_y, output ready);
endinterface

interface dda_out_if import dda_pkg::*; ();
	logic   valid;
	logic   ready;
	coord_t pixel_x;
	coord_t pixel_y;
	logic   last;

	modport source (output valid, pixel_x, pixel_y, last, input ready);
	modport sink (input valid, pixel_x, pixel_y, last, output ready);
endinterface
`default_nettype wire

// File: design/dda_div.sv
// Restoring divider that forms (num << FRAC_BITS) / den for num <= den, one bit a cycle.
`default_nettype none
module dda_div import dda_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);
	localparam int DIV_STEPS = FRAC_BITS + 1;
	localparam int DIV_CW    = $clog2(DIV_STEPS + 1);

	logic                  busy_q;
	logic                  done_q;
	logic [DIV_CW-1:0]     cnt_q;
	logic [COORD_BITS:0]   rem_q;
	coord_t                den_q;
	logic [QUO_W-1:0]      quo_q;
	logic [COORD_BITS:0]   diff;
	logic                  qbit;
	logic [COORD_BITS:0]   rem_keep;

	// One trial subtraction per cycle.
	always_comb begin
		diff     = rem_q - {1'b0, den_q};
		qbit     = (rem_q >= {1'b0, den_q});
		rem_keep = qbit ? diff : rem_q;
	end

	// Control: busy flag, step counter and done pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CW'(DIV_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: partial remainder and quotient shift register.
	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			rem_q <= {1'b0, req.num};
			den_q <= req.den;
			quo_q <= '0;
		end else if (busy_q) begin
			// The kept remainder is below den, so its top bit is clear.
			rem_q <= {rem_keep[COORD_BITS-1:0], 1'b0};
			quo_q <= {quo_q[QUO_W-2:0], qbit};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !req.start)
		else $error("divider started while busy");
	a_done_ends_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && cnt_q == DIV_CW'(1)) |=> (done_q && !busy_q))
		else $error("divider did not finish after its last step");
endmodule
`default_nettype wire

// File: design/dda_line_pixel_generator_top.sv
// Top level of the DDA line pixel generator.
// A load item (action 0) takes two endpoints and sets up a line; it never gives a
// result. When the longer axis spans m >= 2, the two per-step increments are
// formed one after the other in a single shared bit-serial divider, so a load
// keeps the block busy, with input ready low, until both are formed. A step item
// (action 1) advances the position by one increment and gives one pixel item
// whose coordinates are the floored position, with last set on the m-1th pixel;
// the endpoints themselves are not emitted. A step with no line in progress
// gives nothing. The pixel sits in an output register, and a new item is taken
// when that register is empty or is being read in the same cycle.
`default_nettype none
module dda_line_pixel_generator_top import dda_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	dda_in_if.sink   in,
	dda_out_if.source out
);
	dda_state_t state_q, state_d;

	logic [POS_W-1:0]       pos_x_q, pos_y_q;
	logic [STEP_W-1:0]      step_x_q, step_y_q;
	logic [COORD_BITS-1:0]  steps_left_q;
	logic                   line_active_q;
	logic                   neg_x_q, neg_y_q;
	coord_t                 ady_q, m_q;
	logic                   out_valid_q;
	coord_t                 pixel_x_q, pixel_y_q;
	logic                   last_q;

	logic                   accept;
	logic                   load_acc, step_acc;
	logic [COORD_BITS:0]    dx_c, dy_c, ndx_c, ndy_c;
	coord_t                 adx_c, ady_c, m_c;
	logic                   long_c;
	logic [STEP_W-1:0]      quo_ext, step_new;
	logic [POS_W-1:0]       pos_x_nx, pos_y_nx;
	div_req_t               div_req;
	div_rsp_t               div_rsp;

	dda_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Handshake decode.
	assign accept   = in.valid && in.ready;
	assign load_acc = accept && (in.action == ACT_LOAD);
	assign step_acc = accept && (in.action == ACT_STEP) && line_active_q;

	// Endpoint differences, magnitudes and the longer span.
	always_comb begin
		dx_c   = {1'b0, in.end_x} - {1'b0, in.start_x};
		dy_c   = {1'b0, in.end_y} - {1'b0, in.start_y};
		ndx_c  = '0 - dx_c;
		ndy_c  = '0 - dy_c;
		adx_c  = dx_c[COORD_BITS] ? ndx_c[COORD_BITS-1:0] : dx_c[COORD_BITS-1:0];
		ady_c  = dy_c[COORD_BITS] ? ndy_c[COORD_BITS-1:0] : dy_c[COORD_BITS-1:0];
		m_c    = (adx_c > ady_c) ? adx_c : ady_c;
		long_c = (m_c >= COORD_BITS'(2));
	end

	// Signed increment from the divider quotient.
	always_comb begin
		quo_ext  = {1'b0, div_rsp.quo};
		step_new = quo_ext;
		if ((state_q == ST_DIV_X && neg_x_q) || (state_q == ST_DIV_Y && neg_y_q)) begin
			step_new = '0 - quo_ext;
		end
	end

	// Position advance by sign-extended increments.
	assign pos_x_nx = pos_x_q + {{(POS_W-STEP_W){step_x_q[STEP_W-1]}}, step_x_q};
	assign pos_y_nx = pos_y_q + {{(POS_W-STEP_W){step_y_q[STEP_W-1]}}, step_y_q};

	// Sequencer next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (load_acc && long_c) begin
					state_d = ST_DIV_X;
				end
			end
			ST_DIV_X: begin
				if (div_rsp.done) begin
					state_d = ST_DIV_Y;
				end
			end
			ST_DIV_Y: begin
				if (div_rsp.done) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs: input ready and divider requests.
	always_comb begin
		in.ready      = 1'b0;
		div_req.start = 1'b0;
		div_req.num   = ady_q;
		div_req.den   = m_q;
		unique case (state_q)
			ST_IDLE: begin
				in.ready      = !out_valid_q || out.ready;
				div_req.start = load_acc && long_c;
				div_req.num   = adx_c;
				div_req.den   = m_c;
			end
			ST_DIV_X: begin
				div_req.start = div_rsp.done;
			end
			ST_DIV_Y: begin
				div_req.start = 1'b0;
			end
			default: begin
				in.ready = 1'b0;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			line_active_q <= 1'b0;
			steps_left_q  <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			// The pixel register fills on a step and empties when it is read.
			if (step_acc) begin
				out_valid_q <= 1'b1;
			end else if (out.ready) begin
				out_valid_q <= 1'b0;
			end
			if (load_acc) begin
				line_active_q <= 1'b0;
				steps_left_q  <= long_c ? (m_c - 1'b1) : '0;
			end else if (step_acc) begin
				steps_left_q <= steps_left_q - 1'b1;
				if (steps_left_q == COORD_BITS'(1)) begin
					line_active_q <= 1'b0;
				end
			end else if (state_q == ST_DIV_Y && div_rsp.done) begin
				line_active_q <= 1'b1;
			end
		end
	end

	// Payload registers: position, increments and the pixel result.
	always_ff @(posedge clk) begin
		if (load_acc) begin
			pos_x_q  <= {in.start_x, {FRAC_BITS{1'b0}}};
			pos_y_q  <= {in.start_y, {FRAC_BITS{1'b0}}};
			step_x_q <= '0;
			step_y_q <= '0;
			neg_x_q  <= dx_c[COORD_BITS];
			neg_y_q  <= dy_c[COORD_BITS];
			ady_q    <= ady_c;
			m_q      <= m_c;
		end else if (step_acc) begin
			pos_x_q   <= pos_x_nx;
			pos_y_q   <= pos_y_nx;
			pixel_x_q <= pos_x_nx[POS_W-1:FRAC_BITS];
			pixel_y_q <= pos_y_nx[POS_W-1:FRAC_BITS];
			last_q    <= (steps_left_q == COORD_BITS'(1));
		end else if (div_rsp.done) begin
			if (state_q == ST_DIV_X) begin
				step_x_q <= step_new;
			end else if (state_q == ST_DIV_Y) begin
				step_y_q <= step_new;
			end
		end
	end

	assign out.valid   = out_valid_q;
	assign out.pixel_x = pixel_x_q;
	assign out.pixel_y = pixel_y_q;
	assign out.last    = last_q;

	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !in.ready)
		else $error("input taken while increments are being formed");
	a_last_ends_line: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && last_q) |-> !line_active_q)
		else $error("line still active after its last pixel");
	a_active_has_steps: assert property (@(posedge clk) disable iff (!arst_n)
		line_active_q |-> (steps_left_q != '0))
		else $error("active line with no pixels left");
endmodule
`default_nettype wire
